// ===== rtl/dual_wheel_encoder_speed_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual wheel encoder speed block
// Shared implication forms, clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_ENCODER_SPEED_ASSERT_SVH
`define DUAL_WHEEL_ENCODER_SPEED_ASSERT_SVH

// Same-cycle implication.
`define DWES_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwes assertion failed");

// Next-cycle implication.
`define DWES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwes assertion failed");

`endif

// ===== rtl/dwes_pkg.sv =====
// ----------------------------------------------------------------------------
// dwes_pkg
// Widths, codes and the query beat type shared by the encoder speed block.
// ----------------------------------------------------------------------------
package dwes_pkg;

  // Counter width (16 to 32) and the fixed field widths.
  localparam int CNT_W   = 32;
  localparam int MM_W    = 24;
  localparam int MS_W    = 32;
  localparam int EC_W    = 32;
  localparam int DIST_W  = 56;
  localparam int SPEED_W = 64;

  // Product of magnitude and scale, then 1000 times that (1000 < 2^10).
  localparam int PROD_W  = CNT_W + MM_W;
  localparam int NUM_W   = PROD_W + 10;
  localparam int STEP_W  = $clog2(NUM_W);
  // Quotient width with room for at least one bit above the speed field.
  localparam int QX_W    = (NUM_W > SPEED_W) ? NUM_W : SPEED_W + 1;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  // Input beat opcodes.
  localparam logic OPC_EDGE  = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  // One speed query, classified by the front.
  typedef struct packed {
    logic             wheel;
    logic [CNT_W-1:0] mag;
    logic [MS_W-1:0]  ms;
  } query_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

// ===== rtl/dwes_queue.sv =====
// ----------------------------------------------------------------------------
// dwes_queue
// Short first-in first-out queue of speed queries between front and back.
// ----------------------------------------------------------------------------
module dwes_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dwes_pkg::query_t push_data,
  input  logic            pop,
  output dwes_pkg::query_t pop_data,
  output dwes_pkg::queue_status_t status
);
  import dwes_pkg::*;

  query_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  // Status flags come straight from the fill count.
  assign status.full  = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign status.valid = (fill != '0);
  assign pop_data     = entries[rd_ptr];

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule

// ===== rtl/dwes_front.sv =====
// ----------------------------------------------------------------------------
// dwes_front
// Accepts input beats, decodes encoder edges and turns queries into jobs.
// ----------------------------------------------------------------------------
module dwes_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    opcode,
  input  logic                    left_edge,
  input  logic                    left_phase_a,
  input  logic                    right_edge,
  input  logic                    right_phase_a,
  input  logic                    wheel,
  input  logic [dwes_pkg::MS_W-1:0] interval_ms,
  input  dwes_pkg::queue_status_t q_status,
  output logic                    push,
  output dwes_pkg::query_t        push_data
);
  import dwes_pkg::*;

  logic [CNT_W-1:0] wheel_count [2];
  logic [CNT_W-1:0] count_at_last_query [2];
  logic [CNT_W-1:0] left_next;
  logic [CNT_W-1:0] right_next;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] diff;
  logic             accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // x1 decoding: a rising B edge counts down with A high, up otherwise.
  always_comb begin
    left_next  = wheel_count[0];
    right_next = wheel_count[1];
    if (left_edge) begin
      left_next = left_phase_a ? wheel_count[0] - 1'b1 : wheel_count[0] + 1'b1;
    end
    if (right_edge) begin
      right_next = right_phase_a ? wheel_count[1] - 1'b1 : wheel_count[1] + 1'b1;
    end
  end

  // Signed count change since the last query, reported as a magnitude.
  always_comb begin
    cur  = wheel_count[wheel];
    diff = cur - count_at_last_query[wheel];
    push = accept && (opcode == OPC_QUERY);
    push_data.wheel = wheel;
    push_data.mag   = diff[CNT_W-1] ? '0 - diff : diff;
    push_data.ms    = interval_ms;
  end

  // Counter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_count[0]         <= '0;
      wheel_count[1]         <= '0;
      count_at_last_query[0] <= '0;
      count_at_last_query[1] <= '0;
    end else if (accept) begin
      if (opcode == OPC_EDGE) begin
        wheel_count[0] <= left_next;
        wheel_count[1] <= right_next;
      end else begin
        count_at_last_query[wheel] <= cur;
      end
    end
  end
endmodule

// ===== rtl/dwes_back.sv =====
// ----------------------------------------------------------------------------
// dwes_back
// Scales a query to distance and divides to speed, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dwes_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dwes_pkg::MM_W-1:0]     mm_per_count_q16,
  input  dwes_pkg::queue_status_t       q_status,
  input  dwes_pkg::query_t              q_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          which_wheel,
  output logic [dwes_pkg::EC_W-1:0]     count_delta,
  output logic [dwes_pkg::DIST_W-1:0]   distance_mm_q16,
  output logic [dwes_pkg::SPEED_W-1:0]  speed_mm_s_q16,
  output logic                          speed_saturated
);
  import dwes_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t            state;
  query_t            job;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num;
  logic [MS_W-1:0]   rem;
  logic [STEP_W-1:0] step;
  logic              zero_div;
  logic [NUM_W-1:0]  scaled;
  logic [MS_W:0]     shifted;
  logic [MS_W:0]     trial;
  logic [QX_W-1:0]   quot_ext;
  logic              sat;
  logic              out_load;

  assign pop = (state == ST_IDLE) && q_status.valid;

  // 1000 * d as (d << 10) - (d << 4) - (d << 3).
  assign scaled = (NUM_W'(prod) << 10) - (NUM_W'(prod) << 4) - (NUM_W'(prod) << 3);

  // One restoring division step.
  assign shifted = {rem, num[NUM_W-1]};
  assign trial   = shifted - {1'b0, job.ms};

  // Saturate on zero divisor or a quotient above the speed field.
  assign quot_ext = QX_W'(num);
  assign sat      = zero_div || (|quot_ext[QX_W-1:SPEED_W]);

  // A finished job moves into the result register once it is free.
  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  // Sequencer with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_status.valid) begin
            job   <= q_data;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(job.mag) * PROD_W'(mm_per_count_q16);
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          num      <= scaled;
          rem      <= '0;
          step     <= STEP_W'(NUM_W-1);
          zero_div <= (job.ms == '0);
          state    <= (job.ms == '0) ? ST_FIN : ST_DIV;
        end
        ST_DIV: begin
          if (!trial[MS_W]) begin
            rem <= trial[MS_W-1:0];
            num <= {num[NUM_W-2:0], 1'b1};
          end else begin
            rem <= shifted[MS_W-1:0];
            num <= {num[NUM_W-2:0], 1'b0};
          end
          if (step == '0) begin
            state <= ST_FIN;
          end else begin
            step <= step - 1'b1;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            which_wheel     <= job.wheel;
            count_delta     <= EC_W'(job.mag);
            distance_mm_q16 <= DIST_W'(prod);
            speed_mm_s_q16  <= sat ? '1 : quot_ext[SPEED_W-1:0];
            speed_saturated <= sat;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/dual_wheel_encoder_speed.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_encoder_speed
// Two x1 quadrature counters with a speed query per wheel.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): opcode 0 beats carry encoder edges for
// both wheels and produce no result; opcode 1 beats query one wheel's speed.
// Result channel (out_valid/out_ready): one beat per query, in query order.
// Configuration channel (cfg_valid/cfg_ready): cfg_data sets the Q8.16
// millimetres per count; it is always ready and should be written while idle.
// Edge beats are taken every cycle while the query queue has room.
// After acceptance a query is queued, then passes the 32 by 24 multiply,
// the scale by 1000 and the restoring divider that retires one quotient
// bit per cycle, and its result is loaded into the output register. The
// back end takes no new query until the last one leaves it, so the divider
// bounds the sustained query rate. A zero elapsed time skips the divider and saturates at once.
// Reset clears both counters, the stored query counts, the scale register
// and the queue. When the receiver stalls, the result holds in the output
// register, the next query waits finished in the back end, and the front
// keeps taking beats until the two-entry queue is full.
module dual_wheel_encoder_speed (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dwes_pkg::MM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic                          left_edge,
  input  logic                          left_phase_a,
  input  logic                          right_edge,
  input  logic                          right_phase_a,
  input  logic                          wheel,
  input  logic [dwes_pkg::MS_W-1:0]     interval_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          which_wheel,
  output logic [dwes_pkg::EC_W-1:0]     count_delta,
  output logic [dwes_pkg::DIST_W-1:0]   distance_mm_q16,
  output logic [dwes_pkg::SPEED_W-1:0]  speed_mm_s_q16,
  output logic                          speed_saturated
);
  import dwes_pkg::*;

  logic [MM_W-1:0] mm_per_count_q16;
  logic            push;
  logic            pop;
  query_t          push_data;
  query_t          pop_data;
  queue_status_t   q_status;

  // Scale register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_per_count_q16 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mm_per_count_q16 <= cfg_data;
    end
  end

  dwes_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .left_edge     (left_edge),
    .left_phase_a  (left_phase_a),
    .right_edge    (right_edge),
    .right_phase_a (right_phase_a),
    .wheel         (wheel),
    .interval_ms   (interval_ms),
    .q_status      (q_status),
    .push          (push),
    .push_data     (push_data)
  );

  dwes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  dwes_back u_back (
    .clk              (clk),
    .rst              (rst),
    .mm_per_count_q16 (mm_per_count_q16),
    .q_status         (q_status),
    .q_data           (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .which_wheel      (which_wheel),
    .count_delta      (count_delta),
    .distance_mm_q16  (distance_mm_q16),
    .speed_mm_s_q16   (speed_mm_s_q16),
    .speed_saturated  (speed_saturated)
  );
endmodule

// ===== rtl/dwes_checker.sv =====
// ----------------------------------------------------------------------------
// dwes_checker
// Port-level checks on the encoder speed block, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_wheel_encoder_speed_assert.svh"

module dwes_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dwes_pkg::EC_W-1:0]     count_delta,
  input logic [dwes_pkg::DIST_W-1:0]   distance_mm_q16,
  input logic [dwes_pkg::SPEED_W-1:0]  speed_mm_s_q16,
  input logic                          speed_saturated
);
  logic still_ok;

  // No movement gives no distance and, unless saturated, no speed.
  assign still_ok = (distance_mm_q16 == '0) && (speed_saturated || (speed_mm_s_q16 == '0));

  // A stalled result beat holds its speed.
  `DWES_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(speed_mm_s_q16))

  // A saturated speed reads as all ones.
  `DWES_ASSERT_NOW(a_sat_max, clk, rst, out_valid && speed_saturated, speed_mm_s_q16 == '1)

  // A result with no count change shows the still case above.
  `DWES_ASSERT_NOW(a_still, clk, rst, out_valid && (count_delta == '0), still_ok)

  // The count change is a magnitude of a signed wrap difference.
  `DWES_ASSERT_NOW(a_mag_range, clk, rst, out_valid, count_delta <= 32'h8000_0000)
endmodule

bind dual_wheel_encoder_speed dwes_checker u_dwes_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for dual_wheel_encoder_speed
// Drives encoder edge beats and speed queries through the input channel,
// predicts every query result from a local odometry model and checks the
// result channel field by field, over several scale settings and idle mixes.
// ----------------------------------------------------------------------------
module tb;
  import dwes_pkg::*;

  // Wheel select codes and encoder directions (phase A level at a B rise).
  localparam logic WHEEL_LEFT  = 1'b0;
  localparam logic WHEEL_RIGHT = 1'b1;
  localparam logic DIR_FWD     = 1'b0;
  localparam logic DIR_REV     = 1'b1;

  // Cycles to let a query still in flight finish before a scale write.
  localparam int SETTLE_CYCLES = 100;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_BEATS   = 82;
  localparam int NUM_DIRECTED  = 21;

  // One input beat.
  typedef struct packed {
    logic            opc;
    logic            l_edge;
    logic            l_phase;
    logic            r_edge;
    logic            r_phase;
    logic            whl;
    logic [MS_W-1:0] ms;
  } enc_beat_t;

  // One speed report on the result channel.
  typedef struct packed {
    logic               whl;
    logic [EC_W-1:0]    counts;
    logic [DIST_W-1:0]  distance;
    logic [SPEED_W-1:0] speed;
    logic               sat;
  } speed_report_t;

  // Directed stimulus row; known marks a report that is typed in here.
  typedef struct packed {
    enc_beat_t     beat;
    logic          known;
    speed_report_t report;
  } directed_row_t;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    // Queries straight after reset: zero time saturates, full time gives zero.
    '{'{OPC_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, WHEEL_LEFT, 32'd0}, 1'b1,
      '{WHEEL_LEFT, 32'd0, 56'd0, SPEED_MAX, 1'b1}},
    '{'{OPC_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, WHEEL_RIGHT, 32'hFFFF_FFFF}, 1'b1,
      '{WHEEL_RIGHT, 32'd0, 56'd0, 64'd0, 1'b0}},
    // Left steps back across zero; query fields on edge beats are ignored.
    '{'{OPC_EDGE, 1'b1, DIR_REV, 1'b0, 1'b1, WHEEL_RIGHT, 32'hFFFF_FFFF}, 1'b0, '0},
    // Both wheels move in the same beat.
    '{'{OPC_EDGE, 1'b1, DIR_REV, 1'b1, DIR_FWD, WHEEL_LEFT, 32'd0}, 1'b0, '0},
    // Edge beat with no rising edge changes nothing.
    '{'{OPC_EDGE, 1'b0, 1'b1, 1'b0, 1'b1, WHEEL_RIGHT, 32'd12345}, 1'b0, '0},
    // Query with edge fields set, which must be ignored.
    '{'{OPC_QUERY, 1'b1, 1'b0, 1'b1, 1'b1, WHEEL_LEFT, 32'd1}, 1'b0, '0},
    '{'{OPC_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, WHEEL_LEFT, 32'd1}, 1'b1,
      '{WHEEL_LEFT, 32'd0, 56'd0, 64'd0, 1'b0}},
    '{'{OPC_EDGE, 1'b0, 1'b0, 1'b1, DIR_REV, WHEEL_LEFT, 32'd0}, 1'b0, '0},
    '{'{OPC_EDGE, 1'b0, 1'b0, 1'b1, DIR_REV, WHEEL_LEFT, 32'd0}, 1'b0, '0},
    '{'{OPC_EDGE, 1'b0, 1'b0, 1'b1, DIR_REV, WHEEL_LEFT, 32'd0}, 1'b0, '0},
    '{'{OPC_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, WHEEL_RIGHT, 32'd1000}, 1'b0, '0},
    '{'{OPC_EDGE, 1'b1, DIR_FWD, 1'b1, DIR_FWD, WHEEL_RIGHT, 32'd0}, 1'b0, '0},
    '{'{OPC_EDGE, 1'b1, DIR_FWD, 1'b1, DIR_FWD, WHEEL_RIGHT, 32'd0}, 1'b0, '0},
    '{'{OPC_EDGE, 1'b1, DIR_FWD, 1'b0, 1'b0, WHEEL_RIGHT, 32'd0}, 1'b0, '0},
    // Division that truncates.
    '{'{OPC_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, WHEEL_RIGHT, 32'd3}, 1'b0, '0},
    // Zero time with real distance still saturates.
    '{'{OPC_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, WHEEL_LEFT, 32'd0}, 1'b0, '0},
    '{'{OPC_EDGE, 1'b1, DIR_FWD, 1'b0, 1'b0, WHEEL_LEFT, 32'd0}, 1'b0, '0},
    '{'{OPC_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, WHEEL_LEFT, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OPC_EDGE, 1'b1, DIR_REV, 1'b1, DIR_REV, WHEEL_LEFT, 32'd0}, 1'b0, '0},
    '{'{OPC_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, WHEEL_LEFT, 32'd7}, 1'b0, '0},
    '{'{OPC_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, WHEEL_RIGHT, 32'h8000_0000}, 1'b0, '0}
  };

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [MM_W-1:0]    cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               opcode;
  logic               left_edge;
  logic               left_phase_a;
  logic               right_edge;
  logic               right_phase_a;
  logic               wheel;
  logic [MS_W-1:0]    interval_ms;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               which_wheel;
  logic [EC_W-1:0]    count_delta;
  logic [DIST_W-1:0]  distance_mm_q16;
  logic [SPEED_W-1:0] speed_mm_s_q16;
  logic               speed_saturated;

  // Local copy of the odometry state and the scale register.
  logic [CNT_W-1:0] wheel_pos [2];
  logic [CNT_W-1:0] pos_at_query [2];
  logic [MM_W-1:0]  mm_per_count;

  speed_report_t pending_reports [$];
  speed_report_t seen_report;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            errors = 0;
  int            beats_sent = 0;
  int            queries_sent = 0;
  int            saturated_seen = 0;
  int            scale_writes = 0;

  dual_wheel_encoder_speed i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .left_edge       (left_edge),
    .left_phase_a    (left_phase_a),
    .right_edge      (right_edge),
    .right_phase_a   (right_phase_a),
    .wheel           (wheel),
    .interval_ms     (interval_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .which_wheel     (which_wheel),
    .count_delta     (count_delta),
    .distance_mm_q16 (distance_mm_q16),
    .speed_mm_s_q16  (speed_mm_s_q16),
    .speed_saturated (speed_saturated)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("dual_wheel_encoder_speed regression: fail");
    $finish;
  end

  // Applies one beat to the local odometry state; returns 1 with the
  // report when the beat is a speed query.
  function automatic bit odometry_step(input enc_beat_t b, output speed_report_t r);
    logic [CNT_W-1:0]  diff;
    logic [CNT_W-1:0]  mag;
    logic [DIST_W+9:0] scaled;
    logic [DIST_W+9:0] quo;
    r = '0;
    if (b.opc == OPC_EDGE) begin
      if (b.l_edge) wheel_pos[0] = b.l_phase ? wheel_pos[0] - 1'b1 : wheel_pos[0] + 1'b1;
      if (b.r_edge) wheel_pos[1] = b.r_phase ? wheel_pos[1] - 1'b1 : wheel_pos[1] + 1'b1;
      return 1'b0;
    end
    // Count change read as signed, then its magnitude.
    diff = wheel_pos[b.whl] - pos_at_query[b.whl];
    pos_at_query[b.whl] = wheel_pos[b.whl];
    mag = diff[CNT_W-1] ? -diff : diff;
    r.whl      = b.whl;
    r.counts   = EC_W'(mag);
    r.distance = DIST_W'(mag) * DIST_W'(mm_per_count);
    // Exact floor of 1000 * distance / ms, saturating beyond 64 bits.
    scaled = (DIST_W+10)'(r.distance) * (DIST_W+10)'(1000);
    if (b.ms == '0) begin
      r.speed = SPEED_MAX;
      r.sat   = 1'b1;
    end else begin
      quo = scaled / (DIST_W+10)'(b.ms);
      if (quo[DIST_W+9:SPEED_W] != '0) begin
        r.speed = SPEED_MAX;
        r.sat   = 1'b1;
      end else begin
        r.speed = quo[SPEED_W-1:0];
        r.sat   = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Elapsed time with the corners weighted up.
  function automatic logic [MS_W-1:0] pick_ms();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return MS_W'(1);
    if (sel < 15) return '1;
    if (sel < 60) return MS_W'($urandom_range(2000, 1));
    return MS_W'($urandom);
  endfunction

  // Sends one beat, with random idle cycles in front, and records the
  // expected report once the beat is accepted.
  task automatic send_beat(input enc_beat_t b, input logic known, input speed_report_t typed);
    speed_report_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    opcode        <= b.opc;
    left_edge     <= b.l_edge;
    left_phase_a  <= b.l_phase;
    right_edge    <= b.r_edge;
    right_phase_a <= b.r_phase;
    wheel         <= b.whl;
    interval_ms   <= b.ms;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (odometry_step(b, r)) begin
      pending_reports.push_back(known ? typed : r);
      queries_sent++;
    end
    beats_sent++;
  endtask

  // Stops sending, waits for every report and for any query still in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [MM_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mm_per_count = v;
    scale_writes++;
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    errors++;
  endtask

  // Result side: random stalls and the check of every accepted beat.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (speed_saturated) saturated_seen++;
      if (pending_reports.size() == 0) begin
        $display("%0t: result beat for wheel %0d with no query outstanding",
                 $time, which_wheel);
        errors++;
      end else begin
        seen_report = pending_reports.pop_front();
        if (which_wheel !== seen_report.whl)
          report_mismatch("which_wheel", 64'(seen_report.whl), 64'(which_wheel));
        if (count_delta !== seen_report.counts)
          report_mismatch("count_delta", 64'(seen_report.counts), 64'(count_delta));
        if (distance_mm_q16 !== seen_report.distance)
          report_mismatch("distance_mm_q16", 64'(seen_report.distance),
                          64'(distance_mm_q16));
        if (speed_mm_s_q16 !== seen_report.speed)
          report_mismatch("speed_mm_s_q16", seen_report.speed, speed_mm_s_q16);
        if (speed_saturated !== seen_report.sat)
          report_mismatch("speed_saturated", 64'(seen_report.sat), 64'(speed_saturated));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Main sequence: reset, directed rows, then random phases.
  initial begin
    enc_beat_t        b;
    logic [MM_W-1:0]  scale;
    logic             whl;
    logic             dir;
    int               burst;
    int               sent;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    opcode        <= OPC_EDGE;
    left_edge     <= 1'b0;
    left_phase_a  <= 1'b0;
    right_edge    <= 1'b0;
    right_phase_a <= 1'b0;
    wheel         <= WHEEL_LEFT;
    interval_ms   <= '0;
    wheel_pos     = '{default: '0};
    pos_at_query  = '{default: '0};
    mm_per_count  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at a scale of 1.0 mm per count.
    send_idle_pct = 21;
    recv_idle_pct = 77;
    write_scale(24'h01_0000);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_beat(DIRECTED[i].beat, DIRECTED[i].known, DIRECTED[i].report);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Idle mix: sender light and receiver heavy, then swapped, then none.
      send_idle_pct = (p < 2) ? 21 : (p < 4) ? 77 : 0;
      recv_idle_pct = (p < 2) ? 77 : (p < 4) ? 21 : 0;
      case (p)
        0, 5: scale = '1;
        1:    scale = '0;
        3:    scale = MM_W'(1);
        default: scale = MM_W'($urandom_range(24'hFF_FFFF));
      endcase
      write_scale(scale);

      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(99) < 80) begin
          // Motion burst led by one wheel, with random edges on the other, then a query of that wheel.
          whl   = 1'($urandom_range(1));
          dir   = 1'($urandom_range(1));
          burst = $urandom_range(12);
          for (int k = 0; k < burst; k++) begin
            b.opc     = OPC_EDGE;
            b.whl     = 1'($urandom_range(1));
            b.ms      = MS_W'($urandom);
            b.l_edge  = (whl == WHEEL_LEFT) ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
            b.l_phase = (whl == WHEEL_LEFT) ? dir : 1'($urandom_range(1));
            b.r_edge  = (whl == WHEEL_RIGHT) ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
            b.r_phase = (whl == WHEEL_RIGHT) ? dir : 1'($urandom_range(1));
            send_beat(b, 1'b0, '0);
          end
          b.opc     = OPC_QUERY;
          b.whl     = whl;
          b.ms      = pick_ms();
          b.l_edge  = 1'($urandom_range(1));
          b.l_phase = 1'($urandom_range(1));
          b.r_edge  = 1'($urandom_range(1));
          b.r_phase = 1'($urandom_range(1));
          send_beat(b, 1'b0, '0);
          sent += burst + 1;
        end else begin
          // Unstructured beat.
          b.opc     = 1'($urandom_range(1));
          b.whl     = 1'($urandom_range(1));
          b.ms      = pick_ms();
          b.l_edge  = 1'($urandom_range(1));
          b.l_phase = 1'($urandom_range(1));
          b.r_edge  = 1'($urandom_range(1));
          b.r_phase = 1'($urandom_range(1));
          send_beat(b, 1'b0, '0);
          sent++;
        end
      end
      settle();
    end

    $display("Run covered %0d input beats, %0d of them speed queries (%0d saturated),",
             beats_sent, queries_sent, saturated_seen);
    $display("across %0d scale settings and three sender/receiver idle mixes.",
             scale_writes);
    if (errors == 0) begin
      $display("dual_wheel_encoder_speed regression: pass");
    end else begin
      $display("dual_wheel_encoder_speed regression: fail");
    end
    $finish;
  end

endmodule
